/* sv/prlpe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the palette run-length pixel expander.
// No dependencies.
package prlpe_pkg;

  localparam int IDX_W    = 8;
  localparam int CNT_W    = 7;
  localparam int CHAN_W   = 8;
  localparam int RGB_W    = 3 * CHAN_W;
  localparam int CQ_DEPTH = 2;

  localparam logic [CHAN_W-1:0] CHANNEL_KEEP = 8'hFC;

  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  index;
    logic [RGB_W-1:0]  rgb;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic              black;
  } cmd_t;

endpackage

/* sv/palette_run_length_pixel_expand.sv */
`timescale 1ns / 1ps
// Run item: the queue slot, the palette RAM read register, the colour
// register and the output register lie before the first pixel, then one pixel
// per cycle while the output slot is free. A palette load is written as it is popped.
// Up to 2 commands wait in the queue while the back end is busy.
// Synchronous active-low reset empties queue and output; palette is unset.
module palette_run_length_pixel_expand #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_RUN         = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_action,
  input  logic [prlpe_pkg::IDX_W-1:0] in_color_index,
  input  logic [7:0]                  in_load_red,
  input  logic [7:0]                  in_load_green,
  input  logic [7:0]                  in_load_blue,
  input  logic [prlpe_pkg::CNT_W-1:0] in_run_count,
  input  logic                        in_final_pair,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [7:0]                  out_pixel_red,
  output logic [7:0]                  out_pixel_green,
  output logic [7:0]                  out_pixel_blue,
  output logic                        out_run_end,
  output logic                        out_image_end
);
  import prlpe_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_in_cmd, q_out_cmd;

  prlpe_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_RUN         (MAX_RUN)
  ) u_front (
    .in_push        (in_push),
    .in_action      (in_action),
    .in_color_index (in_color_index),
    .in_load_red    (in_load_red),
    .in_load_green  (in_load_green),
    .in_load_blue   (in_load_blue),
    .in_run_count   (in_run_count),
    .in_final_pair  (in_final_pair),
    .q_full         (q_full),
    .in_full        (in_full),
    .q_push         (q_push),
    .q_cmd          (q_in_cmd)
  );

  prlpe_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .empty    (q_empty)
  );

  prlpe_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_RUN         (MAX_RUN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_cmd           (q_out_cmd),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_run_end     (out_run_end),
    .out_image_end   (out_image_end)
  );

`ifndef NO_ASSERTIONS
  a_image_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_image_end) |-> out_run_end)
    else $error("image end without run end");

  a_run_streams: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_run_end) |=> !out_empty)
    else $error("gap inside a run");

  a_pop_with_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");
`endif

endmodule

/* sv/prlpe_ram.sv */
`timescale 1ns / 1ps
// Generic one-write one-read RAM with registered read data.
// No dependencies.
module prlpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/prlpe_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input beats, saturates counts, drops empty runs and
// out-of-range writes, and builds queue commands. Depends on prlpe_pkg.
module prlpe_front #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_RUN         = 64
) (
  input  logic                       in_push,
  input  logic                       in_action,
  input  logic [prlpe_pkg::IDX_W-1:0] in_color_index,
  input  logic [7:0]                 in_load_red,
  input  logic [7:0]                 in_load_green,
  input  logic [7:0]                 in_load_blue,
  input  logic [prlpe_pkg::CNT_W-1:0] in_run_count,
  input  logic                       in_final_pair,
  input  logic                       q_full,
  output logic                       in_full,
  output logic                       q_push,
  output prlpe_pkg::cmd_t            q_cmd
);
  import prlpe_pkg::*;

  logic             in_range;
  logic             is_load;
  logic             keep;
  logic [CNT_W-1:0] sat_count;

  assign in_range  = {1'b0, in_color_index} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign is_load   = (in_action == 1'b0);
  assign sat_count = (in_run_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : in_run_count;
  assign keep      = is_load ? in_range : (in_run_count != '0);

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && keep;

  always_comb begin
    q_cmd.load  = is_load;
    q_cmd.index = in_color_index;
    q_cmd.rgb   = {in_load_red, in_load_green, in_load_blue};
    q_cmd.count = sat_count;
    q_cmd.last  = in_final_pair;
    q_cmd.black = !in_range;
  end

endmodule

/* sv/prlpe_cmdq.sv */
`timescale 1ns / 1ps
// Short command queue between front end and back end.
// Depends on prlpe_pkg.
module prlpe_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  prlpe_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output prlpe_pkg::cmd_t pop_cmd,
  output logic            empty
);
  import prlpe_pkg::*;

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int NW = $clog2(CQ_DEPTH + 1);

  cmd_t          slot_r [CQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == NW'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* sv/prlpe_back.sv */
`timescale 1ns / 1ps
// Back end: owns the palette RAM, executes loads and runs in order, and
// drives the pixel output register. Depends on prlpe_pkg and prlpe_ram.
module prlpe_back #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_RUN         = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prlpe_pkg::cmd_t             q_cmd,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [prlpe_pkg::CHAN_W-1:0] out_pixel_red,
  output logic [prlpe_pkg::CHAN_W-1:0] out_pixel_green,
  output logic [prlpe_pkg::CHAN_W-1:0] out_pixel_blue,
  output logic                        out_run_end,
  output logic                        out_image_end
);
  import prlpe_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = $clog2(MAX_RUN + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EMIT = 3'b100
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [CW-1:0]    remain_r, remain_nxt;
  logic             last_r, last_nxt;
  logic             black_r, black_nxt;
  logic [RGB_W-1:0] color_r, color_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [RGB_W-1:0] out_rgb_r, out_rgb_nxt;
  logic             out_run_end_r, out_run_end_nxt;
  logic             out_image_end_r, out_image_end_nxt;
  logic             slot_free;
  logic             ram_we;
  logic [RGB_W-1:0] ram_rdata;

  assign slot_free = !out_vld_r || out_pop;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign ram_we    = q_pop && q_cmd.load;

  prlpe_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (q_cmd.index[AW-1:0]),
    .wr_data (q_cmd.rgb),
    .rd_addr (q_cmd.index[AW-1:0]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    remain_nxt        = remain_r;
    last_nxt          = last_r;
    black_nxt         = black_r;
    color_nxt         = color_r;
    out_vld_nxt       = out_vld_r;
    out_rgb_nxt       = out_rgb_r;
    out_run_end_nxt   = out_run_end_r;
    out_image_end_nxt = out_image_end_r;

    if (out_pop) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_pop && !q_cmd.load) begin
          remain_nxt = q_cmd.count[CW-1:0];
          last_nxt   = q_cmd.last;
          black_nxt  = q_cmd.black;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        color_nxt = black_r ? '0 : (ram_rdata & {3{CHANNEL_KEEP}});
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_vld_nxt       = 1'b1;
          out_rgb_nxt       = color_r;
          out_run_end_nxt   = (remain_r == CW'(1));
          out_image_end_nxt = (remain_r == CW'(1)) && last_r;
          remain_nxt        = remain_r - 1'b1;
          if (remain_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r        <= remain_nxt;
    last_r          <= last_nxt;
    black_r         <= black_nxt;
    color_r         <= color_nxt;
    out_rgb_r       <= out_rgb_nxt;
    out_run_end_r   <= out_run_end_nxt;
    out_image_end_r <= out_image_end_nxt;
  end

  assign out_empty       = !out_vld_r;
  assign out_pixel_red   = out_rgb_r[3*CHAN_W-1:2*CHAN_W];
  assign out_pixel_green = out_rgb_r[2*CHAN_W-1:CHAN_W];
  assign out_pixel_blue  = out_rgb_r[CHAN_W-1:0];
  assign out_run_end     = out_run_end_r;
  assign out_image_end   = out_image_end_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for palette_run_length_pixel_expand: palette loads and runs
// pass through queue handshakes while a scoreboard predicts each pixel beat.
// Depends on prlpe_pkg and the palette_run_length_pixel_expand RTL.
module tb_top;
  import prlpe_pkg::*;

  localparam int MAX_RUN = 64;

  typedef enum bit {
    ACT_LOAD = 1'b0,
    ACT_RUN  = 1'b1
  } action_e;

  typedef struct {
    action_e          action;
    bit [IDX_W-1:0]   index;
    bit [RGB_W-1:0]   rgb;
    bit [CNT_W-1:0]   count;
    bit               final_pair;
  } run_cmd_t;

  typedef struct {
    bit [CHAN_W-1:0] red;
    bit [CHAN_W-1:0] green;
    bit [CHAN_W-1:0] blue;
    bit              run_end;
    bit              image_end;
  } pixel_t;

  class pixel_scoreboard;
    bit [RGB_W-1:0] palette_copy [256];
    pixel_t         pending_pixels [$];
    int             errors;

    function void note_cmd(run_cmd_t c);
      bit [RGB_W-1:0] colour;
      int unsigned    len;
      pixel_t         px;
      if (c.action == ACT_LOAD) begin
        palette_copy[c.index] = c.rgb;
        return;
      end
      len = (c.count > MAX_RUN) ? MAX_RUN : c.count;
      colour = palette_copy[c.index];
      for (int unsigned k = 0; k < len; k++) begin
        px.red       = colour[23:16] & CHANNEL_KEEP;
        px.green     = colour[15:8] & CHANNEL_KEEP;
        px.blue      = colour[7:0] & CHANNEL_KEEP;
        px.run_end   = (k + 1 == len);
        px.image_end = px.run_end && c.final_pair;
        pending_pixels.push_back(px);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual r=%0h g=%0h b=%0h re=%0b ie=%0b",
                 $time, got.red, got.green, got.blue, got.run_end, got.image_end);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("pixel_red", want.red, got.red);
      compare_field("pixel_green", want.green, got.green);
      compare_field("pixel_blue", want.blue, got.blue);
      compare_field("run_end", want.run_end, got.run_end);
      compare_field("image_end", want.image_end, got.image_end);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic             in_action = 1'b0;
  logic [IDX_W-1:0] in_color_index = '0;
  logic [7:0]       in_load_red = '0;
  logic [7:0]       in_load_green = '0;
  logic [7:0]       in_load_blue = '0;
  logic [CNT_W-1:0] in_run_count = '0;
  logic             in_final_pair = 1'b0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [7:0]       out_pixel_red;
  logic [7:0]       out_pixel_green;
  logic [7:0]       out_pixel_blue;
  logic             out_run_end;
  logic             out_image_end;

  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  bit               loaded [256];
  bit [IDX_W-1:0]   loaded_list [$];
  pixel_scoreboard  sb;

  palette_run_length_pixel_expand DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_color_index  (in_color_index),
    .in_load_red     (in_load_red),
    .in_load_green   (in_load_green),
    .in_load_blue    (in_load_blue),
    .in_run_count    (in_run_count),
    .in_final_pair   (in_final_pair),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_run_end     (out_run_end),
    .out_image_end   (out_image_end)
  );

  always #4 clk = ~clk;

  // pop side: check the beat taken at this edge, then pick the next pop
  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.red       = out_pixel_red;
      got.green     = out_pixel_green;
      got.blue      = out_pixel_blue;
      got.run_end   = out_run_end;
      got.image_end = out_image_end;
      sb.check_pixel(got);
    end
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_cmd(action_e act, bit [IDX_W-1:0] idx, bit [RGB_W-1:0] rgb,
                          bit [CNT_W-1:0] cnt, bit fin);
    run_cmd_t c;
    c.action     = act;
    c.index      = idx;
    c.rgb        = rgb;
    c.count      = cnt;
    c.final_pair = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_action      <= act;
    in_color_index <= idx;
    in_load_red    <= rgb[23:16];
    in_load_green  <= rgb[15:8];
    in_load_blue   <= rgb[7:0];
    in_run_count   <= cnt;
    in_final_pair  <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_cmd(c);
    if (act == ACT_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  initial begin
    int             roll;
    int             sel;
    bit [CNT_W-1:0] cnt;
    bit [IDX_W-1:0] pick;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: palette extremes, ignored fields, zero, full and saturated counts
    send_cmd(ACT_LOAD, 8'h00, 24'hFFFFFF, 7'h7F, 1'b1);
    send_cmd(ACT_LOAD, 8'hFF, 24'h000000, 7'h00, 1'b0);
    send_cmd(ACT_LOAD, 8'h55, 24'h03FCA5, 7'h2A, 1'b1);
    send_cmd(ACT_LOAD, 8'hAA, 24'hFE017F, 7'h55, 1'b0);
    send_cmd(ACT_RUN, 8'h00, 24'hFFFFFF, 7'd1, 1'b0);
    send_cmd(ACT_RUN, 8'hFF, 24'hFFFFFF, 7'd64, 1'b1);
    send_cmd(ACT_RUN, 8'h55, 24'h000000, 7'd65, 1'b0);
    send_cmd(ACT_RUN, 8'hAA, 24'h5A5A5A, 7'd127, 1'b1);
    send_cmd(ACT_RUN, 8'h00, 24'h000000, 7'd0, 1'b1);
    send_cmd(ACT_RUN, 8'h55, 24'hFFFFFF, 7'd0, 1'b0);
    send_cmd(ACT_RUN, 8'hAA, 24'h123456, 7'd2, 1'b1);
    send_cmd(ACT_LOAD, 8'h00, 24'h804002, 7'd3, 1'b0);
    send_cmd(ACT_RUN, 8'h00, 24'hA5A5A5, 7'd3, 1'b0);
    send_cmd(ACT_RUN, 8'hFF, 24'h000000, 7'd1, 1'b1);
    send_cmd(ACT_RUN, 8'h55, 24'h000000, 7'd1, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < 30; n++) begin
        roll = $urandom_range(99);
        if (roll < 25) begin
          send_cmd(ACT_LOAD, 8'($urandom), 24'($urandom), 7'($urandom), 1'($urandom));
        end else begin
          pick = loaded_list[$urandom_range(loaded_list.size() - 1)];
          sel = $urandom_range(99);
          if (sel < 10) cnt = 7'd0;
          else if (sel < 75) cnt = 7'($urandom_range(8, 1));
          else if (sel < 93) cnt = 7'($urandom_range(64, 9));
          else cnt = 7'($urandom_range(127, 65));
          send_cmd(ACT_RUN, pick, 24'($urandom), cnt, $urandom_range(3) == 0);
        end
      end
    end
    in_push <= 1'b0;

    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
